>>> rtl/core/fortho_pkg.sv
// Shared constants for the frame orthonormalizer.
// No dependencies; imported by the top level.
package fortho_pkg;

  localparam int IN_WIDTH_DEF      = 16;
  localparam int OUT_FRAC_BITS_DEF = 14;
  // Upper bound on bits of the multiplier operand consumed per stage of the wide products.
  localparam int MUL_CHUNK_DEF     = 16;

endpackage

>>> rtl/core/fortho_mul.sv
// Pipelined unsigned multiplier, one partial product of a operand by a slice of b per stage.
// Stand-alone; instantiated by frame_orthonormalize.
module fortho_mul #(
  parameter int WA = 64,
  parameter int WB = 32,
  parameter int NS = 3
) (
  input  logic             clk,
  input  logic [NS-1:0]    en,
  input  logic [WA-1:0]    a,
  input  logic [WB-1:0]    b,
  output logic [WA+WB-1:0] p
);

  localparam int CW  = (WB + NS - 1) / NS;
  localparam int BPW = NS * CW;
  localparam int PW  = WA + WB;

  logic [WA-1:0]  a_r   [NS];
  logic [BPW-1:0] b_r   [NS];
  logic [PW-1:0]  acc_r [NS];

  for (genvar i = 0; i < NS; i++) begin : g_stage
    logic [WA-1:0]  a_prev;
    logic [BPW-1:0] b_prev;
    logic [PW-1:0]  acc_prev;
    logic [PW-1:0]  acc_nxt;

    if (i == 0) begin : g_first
      assign a_prev   = a;
      assign b_prev   = BPW'(b);
      assign acc_prev = '0;
    end else begin : g_next
      assign a_prev   = a_r[i-1];
      assign b_prev   = b_r[i-1];
      assign acc_prev = acc_r[i-1];
    end

    always_comb begin
      acc_nxt = acc_prev + (PW'(a_prev * b_prev[i*CW +: CW]) << (i * CW));
    end

    always_ff @(posedge clk) begin
      if (en[i]) begin
        acc_r[i] <= acc_nxt;
      end
    end

    // The operands are only carried on while a later stage still needs them.
    if (i < NS - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en[i]) begin
          a_r[i] <= a_prev;
          b_r[i] <= b_prev;
        end
      end
    end
  end

  assign p = acc_r[NS-1];

endmodule

>>> rtl/core/fortho_unit.sv
// One lane of the normalizer: round(|v| * 2^F / sqrt(S)) one result bit per stage.
// Stand-alone; instantiated by frame_orthonormalize.
module fortho_unit #(
  parameter int SW = 96,
  parameter int F  = 14
) (
  input  logic          clk,
  input  logic [F:0]    en,
  input  logic [SW-1:0] s_in,
  input  logic [SW-1:0] v2_in,
  output logic [F:0]    r_out
);

  // P tracks (2m-1)^2 * S and Q tracks (2m-1) * S, so each trial bit needs
  // only shifted adds of S and Q and one compare against 4 * v^2 * 2^(2F).
  localparam int PW = SW + 2 * F + 4;
  localparam int QW = PW + 2;

  logic [SW-1:0]        s_r   [F];
  logic [PW-1:0]        rhs_r [F];
  logic [PW-1:0]        p_r   [F];
  logic signed [QW-1:0] q_r   [F];
  logic [F:0]           m_r   [F+1];

  for (genvar j = 0; j <= F; j++) begin : g_bit
    localparam int K = F - j;
    logic [SW-1:0]        s_prev;
    logic [PW-1:0]        rhs_prev;
    logic [PW-1:0]        p_prev;
    logic signed [QW-1:0] q_prev;
    logic [F:0]           m_prev;
    logic signed [QW-1:0] p_cand;
    logic signed [QW-1:0] q_cand;
    logic                 take;

    if (j == 0) begin : g_first
      assign s_prev   = s_in;
      assign rhs_prev = PW'(v2_in) << (2 * F + 2);
      assign p_prev   = PW'(s_in);
      assign q_prev   = -$signed(QW'(s_in));
      assign m_prev   = '0;
    end else begin : g_next
      assign s_prev   = s_r[j-1];
      assign rhs_prev = rhs_r[j-1];
      assign p_prev   = p_r[j-1];
      assign q_prev   = q_r[j-1];
      assign m_prev   = m_r[j-1];
    end

    always_comb begin
      p_cand = $signed(QW'(p_prev)) + (q_prev <<< (K + 2))
             + $signed(QW'(s_prev) << (2 * K + 2));
      q_cand = q_prev + $signed(QW'(s_prev) << (K + 1));
      take   = p_cand <= $signed(QW'(rhs_prev));
    end

    always_ff @(posedge clk) begin
      if (en[j]) begin
        m_r[j] <= take ? (m_prev | ((F+1)'(1) << K)) : m_prev;
      end
    end

    if (j < F) begin : g_carry
      always_ff @(posedge clk) begin
        if (en[j]) begin
          s_r[j]   <= s_prev;
          rhs_r[j] <= rhs_prev;
          p_r[j]   <= take ? PW'(p_cand) : p_prev;
          q_r[j]   <= take ? q_cand : q_prev;
        end
      end
    end
  end

  assign r_out = m_r[F];

endmodule

>>> rtl/core/frame_orthonormalize.sv
// Top level of the frame orthonormalizer: cross products, squared lengths and
// per-component normalization in one stalling pipeline.
// Depends on fortho_pkg, fortho_mul and fortho_unit.
//
//   channel   direction  tdata                               tuser
//   in_       slave      normal x/y/z, tangent x/y/z         -
//   out_      master     unit normal, tangent, binormal xyz  degenerate
//
// An item enters every cycle while no stall holds the pipeline; it holds NS wide
// multiplier stages (3 at the default width) and OUT_FRAC_BITS + 1 stages
// of bit-per-stage normalizers.
// Reset (rst_n low at a clock edge) clears the valid bits of every stage.
// Each stage moves forward when it is empty or when the stage after it moves,
// so empty slots close up under a stall and the input stays ready while any
// stage downstream is free, even with a finished result waiting at the output.
module frame_orthonormalize
  import fortho_pkg::*;
#(
  parameter int IN_WIDTH      = IN_WIDTH_DEF,
  parameter int OUT_FRAC_BITS = OUT_FRAC_BITS_DEF,
  localparam int IN_TDW  = ((6 * IN_WIDTH + 7) / 8) * 8,
  localparam int OUT_W   = OUT_FRAC_BITS + 2,
  localparam int OUT_TDW = ((9 * OUT_W + 7) / 8) * 8
) (
  input  logic               clk,
  input  logic               rst_n,
  // normal_x, normal_y, normal_z, tangent_x, tangent_y, tangent_z, zero fill
  input  logic [IN_TDW-1:0]  in_tdata,
  input  logic               in_tvalid,
  output logic               in_tready,
  // unit_normal_x/y/z, unit_tangent_x/y/z, unit_binormal_x/y/z, zero fill
  output logic [OUT_TDW-1:0] out_tdata,
  // degenerate
  output logic [0:0]         out_tuser,
  output logic               out_tvalid,
  input  logic               out_tready
);

  localparam int W   = IN_WIDTH;
  localparam int F   = OUT_FRAC_BITS;
  localparam int NS  = (3 * W + MUL_CHUNK_DEF - 1) / MUL_CHUNK_DEF;
  localparam int SW  = 6 * W;
  localparam int U0  = 4 + NS;          // first normalizer stage
  localparam int NST = U0 + F + 2;      // total stages, output register last
  localparam int SIDE_W = 10 + 2 * W + 4 * W + 3 * (2 * W) + 3 * (4 * W);

  // Stage valid bits and per-stage advance enables.
  logic [NST-1:0] vld_r;
  logic [NST-1:0] vld_prev;
  logic [NST-1:0] en;

  for (genvar k = 0; k < NST; k++) begin : g_en
    assign en[k] = out_tready | ~(&vld_r[NST-1:k]);
  end

  // Valid bit that each stage takes over when it advances.
  assign vld_prev = {vld_r[NST-2:0], in_tvalid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      for (int k = 0; k < NST; k++) begin
        if (en[k]) begin
          vld_r[k] <= vld_prev[k];
        end
      end
    end
  end

  assign in_tready  = en[0];
  assign out_tvalid = vld_r[NST-1];

  // Input unpacking.
  logic signed [W-1:0] in_n [3];
  logic signed [W-1:0] in_t [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      in_n[i] = $signed(in_tdata[i*W +: W]);
      in_t[i] = $signed(in_tdata[(3+i)*W +: W]);
    end
  end

  // Stage 0: the six products of cross(n, t) and the squares of n.
  logic signed [W-1:0]   s0_n_r   [3];
  logic signed [2*W-1:0] s0_p_r   [6];
  logic signed [2*W-1:0] s0_nsq_r [3];
  always_ff @(posedge clk) begin
    if (en[0]) begin
      s0_n_r <= in_n;
      s0_p_r[0] <= in_n[1] * in_t[2];
      s0_p_r[1] <= in_n[2] * in_t[1];
      s0_p_r[2] <= in_n[2] * in_t[0];
      s0_p_r[3] <= in_n[0] * in_t[2];
      s0_p_r[4] <= in_n[0] * in_t[1];
      s0_p_r[5] <= in_n[1] * in_t[0];
      for (int i = 0; i < 3; i++) begin
        s0_nsq_r[i] <= in_n[i] * in_n[i];
      end
    end
  end

  // Stage 1: c = cross(n, t) and |n|^2.
  logic signed [W-1:0]   s1_n_r   [3];
  logic signed [2*W:0]   s1_c_r   [3];
  logic [2*W-1:0]        s1_nsq_r [3];
  logic [2*W+1:0]        s1_sn_r;
  always_ff @(posedge clk) begin
    if (en[1]) begin
      s1_n_r <= s0_n_r;
      for (int i = 0; i < 3; i++) begin
        s1_c_r[i]   <= (2*W+1)'(s0_p_r[2*i]) - (2*W+1)'(s0_p_r[2*i+1]);
        s1_nsq_r[i] <= $unsigned(s0_nsq_r[i]);
      end
      s1_sn_r <= (2*W+2)'($unsigned(s0_nsq_r[0])) + (2*W+2)'($unsigned(s0_nsq_r[1]))
               + (2*W+2)'($unsigned(s0_nsq_r[2]));
    end
  end

  // Stage 2: squares of c and the six products of cross(c, n).
  logic signed [4*W+1:0] s2_csq_r [3];
  logic signed [3*W:0]   s2_tpp_r [6];
  logic [2:0]            s2_nsgn_r;
  logic [2:0]            s2_csgn_r;
  logic [2*W-1:0]        s2_nsq_r [3];
  logic [2*W+1:0]        s2_sn_r;
  always_ff @(posedge clk) begin
    if (en[2]) begin
      for (int i = 0; i < 3; i++) begin
        s2_csq_r[i]  <= s1_c_r[i] * s1_c_r[i];
        s2_nsgn_r[i] <= s1_n_r[i][W-1];
        s2_csgn_r[i] <= s1_c_r[i][2*W];
      end
      s2_tpp_r[0] <= s1_c_r[1] * s1_n_r[2];
      s2_tpp_r[1] <= s1_c_r[2] * s1_n_r[1];
      s2_tpp_r[2] <= s1_c_r[2] * s1_n_r[0];
      s2_tpp_r[3] <= s1_c_r[0] * s1_n_r[2];
      s2_tpp_r[4] <= s1_c_r[0] * s1_n_r[1];
      s2_tpp_r[5] <= s1_c_r[1] * s1_n_r[0];
      s2_nsq_r <= s1_nsq_r;
      s2_sn_r  <= s1_sn_r;
    end
  end

  // Stage 3: |c|^2, t' = cross(c, n) as sign and magnitude, degenerate test.
  logic signed [3*W+1:0] s3_tp_full [3];
  logic [4*W+3:0]        s3_sc_full;
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s3_tp_full[i] = (3*W+2)'(s2_tpp_r[2*i]) - (3*W+2)'(s2_tpp_r[2*i+1]);
    end
    s3_sc_full = (4*W+4)'($unsigned(s2_csq_r[0])) + (4*W+4)'($unsigned(s2_csq_r[1]))
               + (4*W+4)'($unsigned(s2_csq_r[2]));
  end

  logic [3*W-1:0] s3_tpm_r  [3];
  logic [2:0]     s3_tsgn_r;
  logic [2:0]     s3_nsgn_r;
  logic [2:0]     s3_csgn_r;
  logic [2*W-1:0] s3_nsq_r  [3];
  logic [4*W-1:0] s3_csq_r  [3];
  logic [2*W-1:0] s3_sn_r;
  logic [4*W-1:0] s3_sc_r;
  logic           s3_deg_r;
  always_ff @(posedge clk) begin
    if (en[3]) begin
      for (int i = 0; i < 3; i++) begin
        s3_tsgn_r[i] <= s3_tp_full[i][3*W+1];
        s3_tpm_r[i]  <= s3_tp_full[i][3*W+1] ? (3*W)'(-s3_tp_full[i])
                                             : (3*W)'(s3_tp_full[i]);
        s3_csq_r[i]  <= (4*W)'($unsigned(s2_csq_r[i]));
      end
      s3_nsgn_r <= s2_nsgn_r;
      s3_csgn_r <= s2_csgn_r;
      s3_nsq_r  <= s2_nsq_r;
      s3_sn_r   <= (2*W)'(s2_sn_r);
      s3_sc_r   <= (4*W)'(s3_sc_full);
      s3_deg_r  <= (s2_sn_r == '0) || (s3_sc_full == '0);
    end
  end

  // Wide products: |t'|^2 = |c|^2 * |n|^2 and the squares of t'.
  logic [6*W-1:0] st_w;
  logic [6*W-1:0] tsq_w [3];

  fortho_mul #(.WA(4*W), .WB(2*W), .NS(NS)) u_mul_st (
    .clk (clk),
    .en  (en[4 +: NS]),
    .a   (s3_sc_r),
    .b   (s3_sn_r),
    .p   (st_w)
  );

  for (genvar i = 0; i < 3; i++) begin : g_tsq
    fortho_mul #(.WA(3*W), .WB(3*W), .NS(NS)) u_mul_tsq (
      .clk (clk),
      .en  (en[4 +: NS]),
      .a   (s3_tpm_r[i]),
      .b   (s3_tpm_r[i]),
      .p   (tsq_w[i])
    );
  end

  // Everything else rides beside the multipliers.
  logic [SIDE_W-1:0] side_in;
  logic [SIDE_W-1:0] side_r [NS];
  assign side_in = {s3_deg_r, s3_tsgn_r, s3_csgn_r, s3_nsgn_r, s3_sn_r, s3_sc_r,
                    s3_nsq_r[2], s3_nsq_r[1], s3_nsq_r[0],
                    s3_csq_r[2], s3_csq_r[1], s3_csq_r[0]};

  for (genvar k = 0; k < NS; k++) begin : g_side
    if (k == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (en[4]) begin
          side_r[0] <= side_in;
        end
      end
    end else begin : g_next
      always_ff @(posedge clk) begin
        if (en[4+k]) begin
          side_r[k] <= side_r[k-1];
        end
      end
    end
  end

  logic           m_deg;
  logic [8:0]     m_sgn;
  logic [2*W-1:0] m_sn;
  logic [4*W-1:0] m_sc;
  logic [2*W-1:0] m_nsq [3];
  logic [4*W-1:0] m_csq [3];
  assign {m_deg, m_sgn, m_sn, m_sc, m_nsq[2], m_nsq[1], m_nsq[0],
          m_csq[2], m_csq[1], m_csq[0]} = side_r[NS-1];

  // Nine normalizer lanes: normal, tangent, binormal. Sign bits are ordered
  // tangent, binormal, normal from the top.
  logic [SW-1:0] lane_s  [9];
  logic [SW-1:0] lane_v2 [9];
  logic [8:0]    lane_sgn;
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      lane_s[i]    = SW'(m_sn);
      lane_v2[i]   = SW'(m_nsq[i]);
      lane_s[3+i]  = st_w;
      lane_v2[3+i] = tsq_w[i];
      lane_s[6+i]  = SW'(m_sc);
      lane_v2[6+i] = SW'(m_csq[i]);
      lane_sgn[i]   = m_sgn[i];
      lane_sgn[3+i] = m_sgn[6+i];
      lane_sgn[6+i] = m_sgn[3+i];
    end
  end

  logic [F:0] lane_r [9];
  for (genvar i = 0; i < 9; i++) begin : g_lane
    fortho_unit #(.SW(SW), .F(F)) u_unit (
      .clk   (clk),
      .en    (en[U0 +: F+1]),
      .s_in  (lane_s[i]),
      .v2_in (lane_v2[i]),
      .r_out (lane_r[i])
    );
  end

  logic [9:0] uside_r [F+1];
  for (genvar k = 0; k <= F; k++) begin : g_uside
    if (k == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (en[U0]) begin
          uside_r[0] <= {m_deg, lane_sgn};
        end
      end
    end else begin : g_next
      always_ff @(posedge clk) begin
        if (en[U0+k]) begin
          uside_r[k] <= uside_r[k-1];
        end
      end
    end
  end

  // Output register: apply signs and clear everything for a degenerate frame.
  logic [9*OUT_W-1:0] res_nxt;
  always_comb begin
    for (int i = 0; i < 9; i++) begin
      if (uside_r[F][9]) begin
        res_nxt[i*OUT_W +: OUT_W] = '0;
      end else if (uside_r[F][i]) begin
        res_nxt[i*OUT_W +: OUT_W] = -OUT_W'(lane_r[i]);
      end else begin
        res_nxt[i*OUT_W +: OUT_W] = OUT_W'(lane_r[i]);
      end
    end
  end

  logic [9*OUT_W-1:0] out_res_r;
  logic               out_deg_r;
  always_ff @(posedge clk) begin
    if (en[NST-1]) begin
      out_res_r <= res_nxt;
      out_deg_r <= uside_r[F][9];
    end
  end

  assign out_tdata    = OUT_TDW'(out_res_r);
  assign out_tuser[0] = out_deg_r;

endmodule
